@@ hdl/semispace_copying_heap_collector_defines.svh @@
// Assertion macros used by the collector top level.
`ifndef SEMISPACE_COPYING_HEAP_COLLECTOR_DEFINES_SVH
`define SEMISPACE_COPYING_HEAP_COLLECTOR_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define HCGC_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("collector assertion failed");

// Condition implies consequence in the next cycle.
`define HCGC_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("collector assertion failed");

`endif

@@ hdl/hcgc_pkg.sv @@
// Constants and types shared by the collector modules.
`default_nettype none
package hcgc_pkg;
   localparam int HEAP_CELLS  = 8192;
   localparam int IDX_W       = $clog2(HEAP_CELLS);
   localparam int ADDR_W      = IDX_W + 1;
   localparam int PTR_W       = 14;
   localparam int ROOT_COUNT  = 9;
   localparam int WORD_W      = 64;
   localparam int TYPE_W      = 4;
   localparam logic [PTR_W-1:0] LIMIT_RESET = 14'd5000;

   localparam logic [TYPE_W-1:0] CELL_CONS    = 4'd1;
   localparam logic [TYPE_W-1:0] CELL_SYMBOL  = 4'd3;
   localparam logic [TYPE_W-1:0] CELL_CLOSURE = 4'd11;

   localparam logic [2:0] MODE_ALLOC      = 3'd0;
   localparam logic [2:0] MODE_READ_CELL  = 3'd1;
   localparam logic [2:0] MODE_WRITE_WORD = 3'd2;
   localparam logic [2:0] MODE_SET_ROOT   = 3'd3;
   localparam logic [2:0] MODE_READ_ROOT  = 3'd4;
   localparam logic [2:0] MODE_COLLECT    = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_ROOM  = 2'd1;
   localparam logic [1:0] ST_BAD_PTR  = 2'd2;
   localparam logic [1:0] ST_BAD_TYPE = 2'd3;

   typedef struct packed {
      logic type_we;
      logic w1_we;
      logic w2_we;
      logic fwd_we;
   } store_we_type;
endpackage
`default_nettype wire

@@ hdl/hcgc_store.sv @@
// Cell store of both semispaces: type, two words and forwarded flag per cell.
`default_nettype none
module hcgc_store (
   input  wire logic                              clock,
   input  wire logic [hcgc_pkg::ADDR_W-1:0]       addr,
   input  wire hcgc_pkg::store_we_type            we,
   input  wire logic [hcgc_pkg::TYPE_W-1:0]       wr_type,
   input  wire logic [hcgc_pkg::WORD_W-1:0]       wr_w1,
   input  wire logic [hcgc_pkg::WORD_W-1:0]       wr_w2,
   input  wire logic                              wr_fwd,
   output logic      [hcgc_pkg::TYPE_W-1:0]       rd_type,
   output logic      [hcgc_pkg::WORD_W-1:0]       rd_w1,
   output logic      [hcgc_pkg::WORD_W-1:0]       rd_w2,
   output logic                                   rd_fwd
);
   localparam int DEPTH = 2 * hcgc_pkg::HEAP_CELLS;

   logic [hcgc_pkg::TYPE_W-1:0] type_mem [0:DEPTH-1];
   logic [hcgc_pkg::WORD_W-1:0] w1_mem   [0:DEPTH-1];
   logic [hcgc_pkg::WORD_W-1:0] w2_mem   [0:DEPTH-1];
   logic                        fwd_mem  [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (we.type_we) type_mem[addr] <= wr_type;
      if (we.w1_we)   w1_mem[addr]   <= wr_w1;
      if (we.w2_we)   w2_mem[addr]   <= wr_w2;
      if (we.fwd_we)  fwd_mem[addr]  <= wr_fwd;
      rd_type <= type_mem[addr];
      rd_w1   <= w1_mem[addr];
      rd_w2   <= w2_mem[addr];
      rd_fwd  <= fwd_mem[addr];
   end
endmodule
`default_nettype wire

@@ hdl/semispace_copying_heap_collector.sv @@
// Top level: semispace cell heap with a Cheney-style copying collector.
//
// Usage. A request is taken at a rising edge with start high and busy low.
// The result appears for exactly one cycle with rsp_valid high; it cannot be
// held off, so the user must take it in that cycle. busy falls in the cycle
// the result is shown, and a new request may be taken at the edge ending it.
// Allocate, write word, set root, read root and the unused modes answer
// from the execute state; read cell of a non-nil valid pointer passes a
// further read state, because the cell store has a registered read port.
// Collect relocates every root and scans the new space through one shared
// relocation sequence and the single store port: a nil word relocates at
// once, a word whose cell has moved already needs a read of the old cell,
// and a word whose cell is copied also writes the copy and forwarding mark.
// The heap_limit register is written over the csr channel, which is always
// ready; write it only while the block is idle.
// Reset (synchronous, active high) clears the root table, the allocation
// pointer and the semispace select, and loads a limit of 5000 cells. The
// cell store itself is not cleared: cells are only read after being written
// since the last flip, so no clearing pass is needed.
`default_nettype none
`include "semispace_copying_heap_collector_defines.svh"
module semispace_copying_heap_collector (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic [2:0]   req_mode,
   input  wire logic [13:0]  req_target,
   input  wire logic [3:0]   req_cell_type,
   input  wire logic [63:0]  req_first_word,
   input  wire logic [63:0]  req_second_word,
   input  wire logic         req_word_select,
   input  wire logic [3:0]   req_root_index,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [13:0]       rsp_pointer,
   output logic [3:0]        rsp_type_read,
   output logic [63:0]       rsp_word_one_read,
   output logic [63:0]       rsp_word_two_read,
   output logic [13:0]       rsp_used_before,
   output logic [13:0]       rsp_used_after,
   output logic [13:0]       rsp_free_cells,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [13:0]  csr_data
);
   localparam int PW = hcgc_pkg::PTR_W;
   localparam int WW = hcgc_pkg::WORD_W;
   localparam int IW = hcgc_pkg::IDX_W;
   localparam int RC = hcgc_pkg::ROOT_COUNT;

   // Sequencer states.
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EXEC     = 4'd1;
   localparam logic [3:0] S_READ     = 4'd2;
   localparam logic [3:0] S_ROOT     = 4'd3;
   localparam logic [3:0] S_SCAN_RD  = 4'd4;
   localparam logic [3:0] S_SCAN_DAT = 4'd5;
   localparam logic [3:0] S_SCAN_WB  = 4'd6;
   localparam logic [3:0] S_REL0     = 4'd7;
   localparam logic [3:0] S_REL1     = 4'd8;
   localparam logic [3:0] S_REL2     = 4'd9;
   localparam logic [3:0] S_RET      = 4'd10;

   // Callers of the relocation sequence.
   localparam logic [1:0] RET_ROOT = 2'd0;
   localparam logic [1:0] RET_W1   = 2'd1;
   localparam logic [1:0] RET_W2   = 2'd2;

   localparam logic [PW-1:0] CELLS = PW'(hcgc_pkg::HEAP_CELLS);

   logic [3:0]    state_ff, state_in;
   logic [2:0]    mode_ff, mode_in;
   logic [PW-1:0] target_ff, target_in;
   logic [3:0]    ctype_ff, ctype_in;
   logic [WW-1:0] w1_ff, w1_in, w2_ff, w2_in;
   logic          sel_ff, sel_in;
   logic [3:0]    ridx_ff, ridx_in;
   logic          space_ff, space_in;
   logic [PW-1:0] ap_ff, ap_in;
   logic [PW-1:0] limit_ff, limit_in;
   logic [PW-1:0] old_count_ff, old_count_in;
   logic [PW-1:0] root_ff [0:RC-1];
   logic [PW-1:0] root_in [0:RC-1];
   logic [3:0]    rcnt_ff, rcnt_in;
   logic [PW-1:0] scan_ff, scan_in;
   logic [WW-1:0] cw1_ff, cw1_in, cw2_ff, cw2_in;
   logic [WW-1:0] rel_w_ff, rel_w_in;
   logic [PW-1:0] rel_res_ff, rel_res_in;
   logic [hcgc_pkg::ADDR_W-1:0] rel_src_ff, rel_src_in;
   logic [1:0]    ret_ff, ret_in;
   logic [PW-1:0] before_ff, before_in;
   logic          valid_ff, valid_in;
   logic [1:0]    status_ff, status_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [3:0]    tr_ff, tr_in;
   logic [WW-1:0] r1_ff, r1_in, r2_ff, r2_in;

   logic [hcgc_pkg::ADDR_W-1:0] st_addr;
   hcgc_pkg::store_we_type      st_we;
   logic [3:0]                  st_type;
   logic [WW-1:0]               st_w1, st_w2;
   logic                        st_fwd;
   logic [3:0]                  rd_type;
   logic [WW-1:0]               rd_w1, rd_w2;
   logic                        rd_fwd;

   logic          accept;
   logic [PW-1:0] eff_limit;
   logic [PW-1:0] ap_inc;
   logic [PW-1:0] rel_w_low;

   hcgc_store u_store (
      .clock   (clock),
      .addr    (st_addr),
      .we      (st_we),
      .wr_type (st_type),
      .wr_w1   (st_w1),
      .wr_w2   (st_w2),
      .wr_fwd  (st_fwd),
      .rd_type (rd_type),
      .rd_w1   (rd_w1),
      .rd_w2   (rd_w2),
      .rd_fwd  (rd_fwd)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign eff_limit = (limit_ff > CELLS) ? CELLS : limit_ff;
   assign ap_inc    = PW'(ap_ff + 14'd1);
   assign rel_w_low = rel_w_ff[PW-1:0];

   // Results are held in registers; used_after and free_cells follow the live allocation pointer.
   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_pointer       = ptr_ff;
   assign rsp_type_read     = tr_ff;
   assign rsp_word_one_read = r1_ff;
   assign rsp_word_two_read = r2_ff;
   assign rsp_used_before   = before_ff;
   assign rsp_used_after    = ap_ff;
   assign rsp_free_cells    = (eff_limit > ap_ff) ? PW'(eff_limit - ap_ff) : '0;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      target_in    = target_ff;
      ctype_in     = ctype_ff;
      w1_in        = w1_ff;
      w2_in        = w2_ff;
      sel_in       = sel_ff;
      ridx_in      = ridx_ff;
      space_in     = space_ff;
      ap_in        = ap_ff;
      limit_in     = limit_ff;
      old_count_in = old_count_ff;
      root_in      = root_ff;
      rcnt_in      = rcnt_ff;
      scan_in      = scan_ff;
      cw1_in       = cw1_ff;
      cw2_in       = cw2_ff;
      rel_w_in     = rel_w_ff;
      rel_res_in   = rel_res_ff;
      rel_src_in   = rel_src_ff;
      ret_in       = ret_ff;
      before_in    = before_ff;
      valid_in     = 1'b0;
      status_in    = status_ff;
      ptr_in       = ptr_ff;
      tr_in        = tr_ff;
      r1_in        = r1_ff;
      r2_in        = r2_ff;
      st_addr      = '0;
      st_we        = '0;
      st_type      = ctype_ff;
      st_w1        = w1_ff;
      st_w2        = w2_ff;
      st_fwd       = 1'b0;

      if (csr_valid && csr_ready) limit_in = csr_data;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in   = req_mode;
               target_in = req_target;
               ctype_in  = req_cell_type;
               w1_in     = req_first_word;
               w2_in     = req_second_word;
               sel_in    = req_word_select;
               ridx_in   = req_root_index;
               before_in = ap_ff;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = hcgc_pkg::ST_OK;
            ptr_in    = '0;
            tr_in     = '0;
            r1_in     = '0;
            r2_in     = '0;
            valid_in  = 1'b1;
            state_in  = S_IDLE;
            case (mode_ff)
               hcgc_pkg::MODE_ALLOC: begin
                  if (ctype_ff == 4'd0 || ctype_ff > hcgc_pkg::CELL_CLOSURE) begin
                     status_in = hcgc_pkg::ST_BAD_TYPE;
                  end else if (ap_ff >= eff_limit) begin
                     status_in = hcgc_pkg::ST_NO_ROOM;
                  end else begin
                     st_addr = {space_ff, ap_ff[IW-1:0]};
                     st_we   = '{type_we: 1'b1, w1_we: 1'b1, w2_we: 1'b1, fwd_we: 1'b1};
                     ap_in   = ap_inc;
                     ptr_in  = ap_inc;
                  end
               end
               hcgc_pkg::MODE_READ_CELL: begin
                  if (target_ff > ap_ff) begin
                     status_in = hcgc_pkg::ST_BAD_PTR;
                  end else if (target_ff != '0) begin
                     st_addr  = {space_ff, IW'(target_ff - 14'd1)};
                     valid_in = 1'b0;
                     state_in = S_READ;
                  end
               end
               hcgc_pkg::MODE_WRITE_WORD: begin
                  if (target_ff == '0 || target_ff > ap_ff) begin
                     status_in = hcgc_pkg::ST_BAD_PTR;
                  end else begin
                     st_addr     = {space_ff, IW'(target_ff - 14'd1)};
                     st_w2       = w1_ff;
                     st_we.w1_we = !sel_ff;
                     st_we.w2_we = sel_ff;
                  end
               end
               hcgc_pkg::MODE_SET_ROOT: begin
                  if (ridx_ff >= 4'(RC) || target_ff > ap_ff) begin
                     status_in = hcgc_pkg::ST_BAD_PTR;
                  end else begin
                     root_in[ridx_ff] = target_ff;
                  end
               end
               hcgc_pkg::MODE_READ_ROOT: begin
                  if (ridx_ff >= 4'(RC)) begin
                     status_in = hcgc_pkg::ST_BAD_PTR;
                  end else begin
                     ptr_in = root_ff[ridx_ff];
                  end
               end
               hcgc_pkg::MODE_COLLECT: begin
                  // Flip the spaces; the old space is the complement of the new one.
                  old_count_in = ap_ff;
                  space_in     = !space_ff;
                  ap_in        = '0;
                  rcnt_in      = '0;
                  valid_in     = 1'b0;
                  state_in     = S_ROOT;
               end
               default: begin
               end
            endcase
         end
         S_READ: begin
            tr_in    = rd_type;
            r1_in    = rd_w1;
            r2_in    = rd_w2;
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_ROOT: begin
            if (rcnt_ff == 4'(RC)) begin
               scan_in  = '0;
               state_in = S_SCAN_RD;
            end else begin
               rel_w_in = WW'(root_ff[rcnt_ff]);
               ret_in   = RET_ROOT;
               state_in = S_REL0;
            end
         end
         S_SCAN_RD: begin
            if (scan_ff == ap_ff) begin
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               st_addr  = {space_ff, scan_ff[IW-1:0]};
               state_in = S_SCAN_DAT;
            end
         end
         S_SCAN_DAT: begin
            cw1_in = rd_w1;
            cw2_in = rd_w2;
            if (rd_type == hcgc_pkg::CELL_CONS || rd_type == hcgc_pkg::CELL_CLOSURE) begin
               rel_w_in = rd_w1;
               ret_in   = RET_W1;
               state_in = S_REL0;
            end else if (rd_type == hcgc_pkg::CELL_SYMBOL) begin
               rel_w_in = rd_w2;
               ret_in   = RET_W2;
               state_in = S_REL0;
            end else begin
               scan_in  = PW'(scan_ff + 14'd1);
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_WB: begin
            st_addr  = {space_ff, scan_ff[IW-1:0]};
            st_w1    = cw1_ff;
            st_w2    = cw2_ff;
            st_we    = '{type_we: 1'b0, w1_we: 1'b1, w2_we: 1'b1, fwd_we: 1'b0};
            scan_in  = PW'(scan_ff + 14'd1);
            state_in = S_SCAN_RD;
         end
         S_REL0: begin
            // Nil and dangling words relocate to nil.
            if (rel_w_ff == '0 || (|rel_w_ff[WW-1:PW]) || rel_w_low > old_count_ff) begin
               rel_res_in = '0;
               state_in   = S_RET;
            end else begin
               rel_src_in = {!space_ff, IW'(rel_w_low - 14'd1)};
               st_addr    = {!space_ff, IW'(rel_w_low - 14'd1)};
               state_in   = S_REL1;
            end
         end
         S_REL1: begin
            if (rd_fwd) begin
               rel_res_in = rd_w1[PW-1:0];
               state_in   = S_RET;
            end else if (ap_ff >= CELLS) begin
               rel_res_in = '0;
               state_in   = S_RET;
            end else begin
               st_addr  = {space_ff, ap_ff[IW-1:0]};
               st_type  = rd_type;
               st_w1    = rd_w1;
               st_w2    = rd_w2;
               st_fwd   = 1'b0;
               st_we    = '{type_we: 1'b1, w1_we: 1'b1, w2_we: 1'b1, fwd_we: 1'b1};
               state_in = S_REL2;
            end
         end
         S_REL2: begin
            // Leave the forwarding mark and new address in the old cell.
            st_addr    = rel_src_ff;
            st_w1      = WW'(ap_inc);
            st_fwd     = 1'b1;
            st_we      = '{type_we: 1'b0, w1_we: 1'b1, w2_we: 1'b0, fwd_we: 1'b1};
            ap_in      = ap_inc;
            rel_res_in = ap_inc;
            state_in   = S_RET;
         end
         S_RET: begin
            case (ret_ff)
               RET_ROOT: begin
                  root_in[rcnt_ff] = rel_res_ff;
                  rcnt_in          = 4'(rcnt_ff + 4'd1);
                  state_in         = S_ROOT;
               end
               RET_W1: begin
                  cw1_in   = WW'(rel_res_ff);
                  rel_w_in = cw2_ff;
                  ret_in   = RET_W2;
                  state_in = S_REL0;
               end
               default: begin
                  cw2_in   = WW'(rel_res_ff);
                  state_in = S_SCAN_WB;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         space_ff <= 1'b0;
         ap_ff    <= '0;
         limit_ff <= hcgc_pkg::LIMIT_RESET;
         valid_ff <= 1'b0;
         for (int i = 0; i < RC; i++) root_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         space_ff <= space_in;
         ap_ff    <= ap_in;
         limit_ff <= limit_in;
         valid_ff <= valid_in;
         root_ff  <= root_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      target_ff    <= target_in;
      ctype_ff     <= ctype_in;
      w1_ff        <= w1_in;
      w2_ff        <= w2_in;
      sel_ff       <= sel_in;
      ridx_ff      <= ridx_in;
      old_count_ff <= old_count_in;
      rcnt_ff      <= rcnt_in;
      scan_ff      <= scan_in;
      cw1_ff       <= cw1_in;
      cw2_ff       <= cw2_in;
      rel_w_ff     <= rel_w_in;
      rel_res_ff   <= rel_res_in;
      rel_src_ff   <= rel_src_in;
      ret_ff       <= ret_in;
      before_ff    <= before_in;
      status_ff    <= status_in;
      ptr_ff       <= ptr_in;
      tr_ff        <= tr_in;
      r1_ff        <= r1_in;
      r2_ff        <= r2_in;
   end

   // A result is only shown once the sequencer is back at rest.
   `HCGC_ASSERT_NOW(a_result_when_idle, clock, reset, valid_ff, state_ff == S_IDLE)
   // The allocation pointer never exceeds one semispace.
   `HCGC_ASSERT_NOW(a_ap_in_range, clock, reset, 1'b1, ap_ff <= CELLS)
   // An accepted request makes the block busy on the next cycle.
   `HCGC_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, busy)
   // During the scan, the scan pointer never passes the allocation pointer.
   `HCGC_ASSERT_NOW(a_scan_behind_ap, clock, reset, state_ff == S_SCAN_RD, scan_ff <= ap_ff)
endmodule
`default_nettype wire

@@ test/semispace_copying_heap_collector_test.sv @@
// Self-checking testbench for the semispace copying heap collector.
`default_nettype none
module semispace_copying_heap_collector_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Spare modes that the block must answer as no-operations.
   localparam logic [2:0]  MODE_SPARE_A = 3'd6;
   localparam logic [2:0]  MODE_SPARE_B = 3'd7;
   localparam logic [3:0]  CELL_NONE    = 4'd0;
   localparam logic [3:0]  CELL_FLONUM  = 4'd2;
   localparam logic [3:0]  CELL_TOP     = 4'd15;
   localparam int          CYCLE_LIMIT  = 3000000;

   typedef struct packed {
      logic [1:0]  status;
      logic [13:0] pointer;
      logic [3:0]  cell_type;
      logic [63:0] word_one;
      logic [63:0] word_two;
      logic [13:0] used_before;
      logic [13:0] used_after;
      logic [13:0] free_cells;
   } heap_answer_type;

   // The scoreboard keeps its own image of both semispaces and the roots.
   // It works out the answer to every accepted request and checks the
   // answers of the block against that, oldest first.
   class heap_scoreboard;
      bit [3:0]        type_mem [2*hcgc_pkg::HEAP_CELLS];
      bit [63:0]       one_mem  [2*hcgc_pkg::HEAP_CELLS];
      bit [63:0]       two_mem  [2*hcgc_pkg::HEAP_CELLS];
      bit              moved    [2*hcgc_pkg::HEAP_CELLS];
      int              roots    [hcgc_pkg::ROOT_COUNT];
      int              space;
      int              ap;
      int              limit;
      int              errors;
      heap_answer_type answers_due [$];

      function new();
         foreach (roots[r]) roots[r] = 0;
         space  = 0;
         ap     = 0;
         limit  = int'(hcgc_pkg::LIMIT_RESET);
         errors = 0;
      endfunction

      function void set_limit(logic [13:0] v);
         limit = v;
      endfunction

      function int usable();
         return (limit > hcgc_pkg::HEAP_CELLS) ? hcgc_pkg::HEAP_CELLS : limit;
      endfunction

      // Copy one old-space cell unless it has moved already; give its new
      // pointer. Words that are not live pointers become nil.
      function logic [63:0] forward(logic [63:0] w, int old_count, int old_base,
                                    int new_base);
         int src;
         int dst;
         if (w == 0 || w > old_count) return 0;
         src = old_base + int'(w) - 1;
         if (moved[src]) return one_mem[src];
         if (ap >= hcgc_pkg::HEAP_CELLS) return 0;
         dst = new_base + ap;
         type_mem[dst] = type_mem[src];
         one_mem[dst]  = one_mem[src];
         two_mem[dst]  = two_mem[src];
         moved[dst]    = 0;
         ap++;
         moved[src]    = 1;
         one_mem[src]  = ap;
         return ap;
      endfunction

      function void collect();
         int old_count;
         int old_base;
         int new_base;
         int c;
         old_count = ap;
         old_base  = space * hcgc_pkg::HEAP_CELLS;
         space     = space ^ 1;
         new_base  = space * hcgc_pkg::HEAP_CELLS;
         ap        = 0;
         foreach (roots[r]) roots[r] = forward(roots[r], old_count, old_base, new_base);
         // The scan pointer chases the allocation pointer, Cheney style.
         for (int i = 0; i < ap; i++) begin
            c = new_base + i;
            if (type_mem[c] == hcgc_pkg::CELL_CONS ||
                type_mem[c] == hcgc_pkg::CELL_CLOSURE) begin
               one_mem[c] = forward(one_mem[c], old_count, old_base, new_base);
               two_mem[c] = forward(two_mem[c], old_count, old_base, new_base);
            end else if (type_mem[c] == hcgc_pkg::CELL_SYMBOL) begin
               two_mem[c] = forward(two_mem[c], old_count, old_base, new_base);
            end
         end
      endfunction

      function void note(logic [2:0] m, logic [13:0] tgt, logic [3:0] ct,
                         logic [63:0] a, logic [63:0] b, logic sel, logic [3:0] ri);
         heap_answer_type e;
         int base;
         int c;
         e = '0;
         base = space * hcgc_pkg::HEAP_CELLS;
         e.used_before = ap;
         case (m)
            hcgc_pkg::MODE_ALLOC: begin
               if (ct < 1 || ct > 11) e.status = hcgc_pkg::ST_BAD_TYPE;
               else if (ap >= usable()) e.status = hcgc_pkg::ST_NO_ROOM;
               else begin
                  c = base + ap;
                  type_mem[c] = ct;
                  one_mem[c]  = a;
                  two_mem[c]  = b;
                  moved[c]    = 0;
                  ap++;
                  e.pointer = ap;
               end
            end
            hcgc_pkg::MODE_READ_CELL: begin
               if (tgt > ap) e.status = hcgc_pkg::ST_BAD_PTR;
               else if (tgt != 0) begin
                  c = base + tgt - 1;
                  e.cell_type = type_mem[c];
                  e.word_one  = one_mem[c];
                  e.word_two  = two_mem[c];
               end
            end
            hcgc_pkg::MODE_WRITE_WORD: begin
               if (tgt == 0 || tgt > ap) e.status = hcgc_pkg::ST_BAD_PTR;
               else if (sel) two_mem[base + tgt - 1] = a;
               else one_mem[base + tgt - 1] = a;
            end
            hcgc_pkg::MODE_SET_ROOT: begin
               if (ri >= hcgc_pkg::ROOT_COUNT || tgt > ap) e.status = hcgc_pkg::ST_BAD_PTR;
               else roots[ri] = tgt;
            end
            hcgc_pkg::MODE_READ_ROOT: begin
               if (ri >= hcgc_pkg::ROOT_COUNT) e.status = hcgc_pkg::ST_BAD_PTR;
               else e.pointer = roots[ri];
            end
            hcgc_pkg::MODE_COLLECT: collect();
            default: ;
         endcase
         e.used_after = ap;
         e.free_cells = (usable() > ap) ? usable() - ap : 0;
         answers_due.push_back(e);
      endfunction

      task report(string field, logic [63:0] got, logic [63:0] want);
         $display("mismatch in %s: got %0h, expected %0h", field, got, want);
         errors++;
      endtask

      task check(heap_answer_type g);
         heap_answer_type e;
         if (answers_due.size() == 0) begin
            $display("unexpected response with status %0d", g.status);
            errors++;
            return;
         end
         e = answers_due.pop_front();
         if (g.status !== e.status) report("status", g.status, e.status);
         if (g.pointer !== e.pointer) report("pointer", g.pointer, e.pointer);
         if (g.cell_type !== e.cell_type) report("type_read", g.cell_type, e.cell_type);
         if (g.word_one !== e.word_one) report("word_one_read", g.word_one, e.word_one);
         if (g.word_two !== e.word_two) report("word_two_read", g.word_two, e.word_two);
         if (g.used_before !== e.used_before)
            report("used_before", g.used_before, e.used_before);
         if (g.used_after !== e.used_after) report("used_after", g.used_after, e.used_after);
         if (g.free_cells !== e.free_cells) report("free_cells", g.free_cells, e.free_cells);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_mode = '0;
   logic [13:0] req_target = '0;
   logic [3:0]  req_cell_type = '0;
   logic [63:0] req_first_word = '0;
   logic [63:0] req_second_word = '0;
   logic        req_word_select = 1'b0;
   logic [3:0]  req_root_index = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [13:0] rsp_pointer;
   logic [3:0]  rsp_type_read;
   logic [63:0] rsp_word_one_read;
   logic [63:0] rsp_word_two_read;
   logic [13:0] rsp_used_before;
   logic [13:0] rsp_used_after;
   logic [13:0] rsp_free_cells;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [13:0] csr_data = '0;

   heap_scoreboard heap_sb = new();
   int cycles = 0;
   int idle_pct = 0;

   semispace_copying_heap_collector dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_target(req_target), .req_cell_type(req_cell_type),
      .req_first_word(req_first_word), .req_second_word(req_second_word),
      .req_word_select(req_word_select), .req_root_index(req_root_index),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_pointer(rsp_pointer),
      .rsp_type_read(rsp_type_read), .rsp_word_one_read(rsp_word_one_read),
      .rsp_word_two_read(rsp_word_two_read), .rsp_used_before(rsp_used_before),
      .rsp_used_after(rsp_used_after), .rsp_free_cells(rsp_free_cells),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Cycle counter doubling as the watchdog: a stuck handshake or a
   // collect that never finishes ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Responses are shown for one cycle only, so every strobe is checked.
   // Values read right after the edge are the ones from before it.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         heap_sb.check({rsp_status, rsp_pointer, rsp_type_read, rsp_word_one_read,
                        rsp_word_two_read, rsp_used_before, rsp_used_after,
                        rsp_free_cells});
   end

   // Present one request and hold it until the block takes it. If the next
   // request follows at once, start simply stays high.
   task automatic issue(logic [2:0] m, logic [13:0] tgt, logic [3:0] ct,
                        logic [63:0] a, logic [63:0] b, logic sel, logic [3:0] ri);
      int gap;
      start           <= 1'b1;
      req_mode        <= m;
      req_target      <= tgt;
      req_cell_type   <= ct;
      req_first_word  <= a;
      req_second_word <= b;
      req_word_select <= sel;
      req_root_index  <= ri;
      do @(posedge clock); while (busy);
      heap_sb.note(m, tgt, ct, a, b, sel, ri);
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Let every outstanding response arrive, then idle with start low.
   task automatic drain();
      start <= 1'b0;
      while (heap_sb.answers_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic [13:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      heap_sb.set_limit(v);
   endtask

   // Word contents that look like pointers most of the time, so that the
   // collector sees real structure, plus some dangling and random words.
   function automatic logic [63:0] pointer_word();
      case ($urandom_range(9))
         7: return 64'd0;
         8: return {$urandom, $urandom};
         9: return 64'($urandom_range(0, 16383));
         default: return 64'($urandom_range(0, heap_sb.ap + 2));
      endcase
   endfunction

   function automatic logic [13:0] cell_target();
      if ($urandom_range(99) < 88) return 14'($urandom_range(0, heap_sb.ap + 1));
      return 14'($urandom_range(0, 16383));
   endfunction

   task automatic random_request();
      int pick;
      logic [3:0] ct;
      pick = $urandom_range(99);
      if (pick < 38) begin
         case ($urandom_range(9))
            0: ct = hcgc_pkg::CELL_SYMBOL;
            1, 2: ct = hcgc_pkg::CELL_CONS;
            3: ct = hcgc_pkg::CELL_CLOSURE;
            4: ct = CELL_FLONUM;
            5: ct = ($urandom_range(1) != 0) ? CELL_NONE : 4'($urandom_range(12, 15));
            default: ct = 4'($urandom_range(1, 11));
         endcase
         issue(hcgc_pkg::MODE_ALLOC, 14'($urandom), ct, pointer_word(), pointer_word(),
               1'($urandom), 4'($urandom));
      end else if (pick < 54)
         issue(hcgc_pkg::MODE_READ_CELL, cell_target(), 4'($urandom),
               {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom), 4'($urandom));
      else if (pick < 66)
         issue(hcgc_pkg::MODE_WRITE_WORD, cell_target(), 4'($urandom), pointer_word(),
               {$urandom, $urandom}, 1'($urandom), 4'($urandom));
      else if (pick < 79)
         issue(hcgc_pkg::MODE_SET_ROOT, cell_target(), 4'($urandom), {$urandom, $urandom},
               {$urandom, $urandom}, 1'($urandom),
               ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8)));
      else if (pick < 88)
         issue(hcgc_pkg::MODE_READ_ROOT, 14'($urandom), 4'($urandom), {$urandom, $urandom},
               {$urandom, $urandom}, 1'($urandom), 4'($urandom));
      else if (pick < 97)
         issue(hcgc_pkg::MODE_COLLECT, 14'($urandom), 4'($urandom), {$urandom, $urandom},
               {$urandom, $urandom}, 1'($urandom), 4'($urandom));
      else
         issue(($urandom_range(1) != 0) ? MODE_SPARE_A : MODE_SPARE_B, 14'($urandom),
               4'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
               1'($urandom), 4'($urandom));
   endtask

   initial begin
      logic [13:0] limits [6];
      int          idles [6];
      limits = '{14'd40, 14'd16383, 14'd3, 14'd200, 14'd8192, 14'd64};
      idles  = '{0, 71, 30, 0, 71, 30};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with the reset limit of 5000 cells.
      issue(hcgc_pkg::MODE_READ_CELL, 14'd0, CELL_NONE, '0, '0, 1'b0, 4'd0);   // nil read
      issue(hcgc_pkg::MODE_READ_CELL, 14'd1, CELL_NONE, '0, '0, 1'b0, 4'd0);   // beyond heap
      issue(hcgc_pkg::MODE_WRITE_WORD, 14'd0, CELL_NONE, '1, '0, 1'b1, 4'd0);  // nil write
      issue(hcgc_pkg::MODE_ALLOC, 14'd0, CELL_NONE, '1, '1, 1'b0, 4'd0);       // bad types
      issue(hcgc_pkg::MODE_ALLOC, 14'd0, CELL_TOP, '1, '1, 1'b0, 4'd0);
      // A cons that points at itself.
      issue(hcgc_pkg::MODE_ALLOC, 14'd0, hcgc_pkg::CELL_CONS, 64'd0, 64'd1, 1'b0, 4'd0);
      issue(hcgc_pkg::MODE_ALLOC, 14'd0, hcgc_pkg::CELL_SYMBOL, '1, 64'd1, 1'b0, 4'd0);
      // A closure with one dangling word.
      issue(hcgc_pkg::MODE_ALLOC, 14'd0, hcgc_pkg::CELL_CLOSURE, 64'd2, 64'd9, 1'b0, 4'd0);
      issue(hcgc_pkg::MODE_ALLOC, 14'd0, CELL_FLONUM, '1, '1, 1'b0, 4'd0);
      issue(hcgc_pkg::MODE_READ_CELL, 14'd4, CELL_NONE, '0, '0, 1'b0, 4'd0);
      issue(hcgc_pkg::MODE_WRITE_WORD, 14'd2, CELL_NONE, 64'd4, '0, 1'b1, 4'd0);
      issue(hcgc_pkg::MODE_WRITE_WORD, 14'd4, CELL_NONE, '0, '0, 1'b0, 4'd0);
      issue(hcgc_pkg::MODE_SET_ROOT, 14'd3, CELL_NONE, '0, '0, 1'b0, 4'd0);
      issue(hcgc_pkg::MODE_SET_ROOT, 14'd4, CELL_NONE, '0, '0, 1'b0, 4'd8);
      issue(hcgc_pkg::MODE_SET_ROOT, 14'd1, CELL_NONE, '0, '0, 1'b0, 4'd9);    // bad slot
      issue(hcgc_pkg::MODE_SET_ROOT, 14'd5, CELL_NONE, '0, '0, 1'b0, 4'd1);    // above use
      issue(hcgc_pkg::MODE_READ_ROOT, 14'd0, CELL_NONE, '0, '0, 1'b0, 4'd15);
      issue(MODE_SPARE_A, '1, CELL_TOP, '1, '1, 1'b1, 4'd15);
      issue(MODE_SPARE_B, '0, CELL_NONE, '0, '0, 1'b0, 4'd0);
      issue(hcgc_pkg::MODE_COLLECT, 14'd0, CELL_NONE, '0, '0, 1'b0, 4'd0);
      issue(hcgc_pkg::MODE_READ_ROOT, 14'd0, CELL_NONE, '0, '0, 1'b0, 4'd0);
      issue(hcgc_pkg::MODE_READ_CELL, 14'd1, CELL_NONE, '0, '0, 1'b0, 4'd0);
      issue(hcgc_pkg::MODE_READ_CELL, 14'd2, CELL_NONE, '0, '0, 1'b0, 4'd0);
      // A limit below the cells in use, then a limit of zero.
      write_limit(14'd1);
      issue(hcgc_pkg::MODE_ALLOC, 14'd0, hcgc_pkg::CELL_CONS, '0, '0, 1'b0, 4'd0);
      write_limit(14'd0);
      issue(hcgc_pkg::MODE_COLLECT, 14'd0, CELL_NONE, '0, '0, 1'b0, 4'd0);
      issue(hcgc_pkg::MODE_ALLOC, 14'd0, hcgc_pkg::CELL_CONS, '0, '0, 1'b0, 4'd0);

      // Random phases over several limits and idle rates.
      for (int p = 0; p < 6; p++) begin
         write_limit(limits[p]);
         idle_pct = idles[p];
         for (int n = 0; n < 220; n++) begin
            // Once, let the pipeline run dry before the next request.
            if (p == 1 && n == 110) drain();
            random_request();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (heap_sb.errors == 0 && heap_sb.answers_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire
